// ----- hdl/mbr_pkg.sv -----
// Shared types, field widths and branch kind codes for the branch resolve block.
package mbr_pkg;

    // Field widths.
    localparam int KindWidth = 4;
    localparam int WordWidth = 32;
    localparam int RegWidth  = 5;

    // Branch kind codes.
    localparam logic [KindWidth-1:0] KIND_J      = 4'd0;
    localparam logic [KindWidth-1:0] KIND_JAL    = 4'd1;
    localparam logic [KindWidth-1:0] KIND_JR     = 4'd2;
    localparam logic [KindWidth-1:0] KIND_JALR   = 4'd3;
    localparam logic [KindWidth-1:0] KIND_BEQ    = 4'd4;
    localparam logic [KindWidth-1:0] KIND_BNE    = 4'd5;
    localparam logic [KindWidth-1:0] KIND_BLEZ   = 4'd6;
    localparam logic [KindWidth-1:0] KIND_BGTZ   = 4'd7;
    localparam logic [KindWidth-1:0] KIND_REGIMM = 4'd8;

    // Regimm sub-code in bits 20:17 that selects the linking forms.
    localparam logic [3:0] REGIMM_LINK_CODE = 4'd8;

    // Return address register of jal and the linking regimm forms.
    localparam logic [RegWidth-1:0] LINK_REG_RA = 5'd31;

    // Region bits of the PC kept by absolute jumps.
    localparam logic [WordWidth-1:0] JUMP_REGION_MASK = 32'hF000_0000;

    // Size of one instruction in bytes.
    localparam logic [WordWidth-1:0] INSTR_BYTES = 32'd4;

    // One branch to resolve.
    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic [WordWidth-1:0] instr_word;
        logic [WordWidth-1:0] rs_value;
        logic [WordWidth-1:0] rt_value;
        logic [WordWidth-1:0] pc_after_slot;
        logic                 in_slot;
    } branch_item_t;

    // One resolution result.
    typedef struct packed {
        logic [WordWidth-1:0] new_pc;
        logic                 taken;
        logic                 link_write;
        logic [RegWidth-1:0]  link_reg;
        logic [WordWidth-1:0] link_value;
        logic                 fault;
    } result_item_t;

endpackage

// ----- hdl/mbr_in_if.sv -----
// Channel that carries branch items into the resolve block.
interface mbr_in_if;
    import mbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KindWidth-1:0] kind;
    logic [WordWidth-1:0] instr_word;
    logic [WordWidth-1:0] rs_value;
    logic [WordWidth-1:0] rt_value;
    logic [WordWidth-1:0] pc_after_slot;
    logic                 in_slot;

    modport source (
        output valid, kind, instr_word, rs_value, rt_value, pc_after_slot, in_slot,
        input  ready
    );

    modport sink (
        input  valid, kind, instr_word, rs_value, rt_value, pc_after_slot, in_slot,
        output ready
    );
endinterface

// ----- hdl/mbr_out_if.sv -----
// Channel that carries resolution results out of the resolve block.
interface mbr_out_if;
    import mbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] new_pc;
    logic                 taken;
    logic                 link_write;
    logic [RegWidth-1:0]  link_reg;
    logic [WordWidth-1:0] link_value;
    logic                 fault;

    modport source (
        output valid, new_pc, taken, link_write, link_reg, link_value, fault,
        input  ready
    );

    modport sink (
        input  valid, new_pc, taken, link_write, link_reg, link_value, fault,
        output ready
    );
endinterface

// ----- hdl/mips_branch_resolve.sv -----
// Top level of the MIPS jump and branch resolve block.
//
// Usage: a branch item (kind, instruction word, rs and rt values, the PC after
// the delay slot and the delay-slot flag) enters on the branch channel, and
// one result item (new PC, taken, link write, link register, link value and
// fault) leaves on the result channel for every branch item.
// Both channels move an item at a clock edge where valid and ready are high.
// The item is captured in the input register, resolved by one target adder and
// the compare logic, and captured in the result register, which drives the
// result channel.
// Throughput is one item per cycle while the result channel does not stall;
// the input register and the result register form a two-entry pipeline, so a
// new item is taken while a finished result still waits on the result channel.
// When the receiver stalls, the result holds and the input register fills;
// branch.ready falls only once both registers hold items.
// Reset empties both registers; no result is shown until an item is taken.
module mips_branch_resolve (
    input  logic             clk,
    input  logic             rst_n,
    mbr_in_if.sink           branch,
    mbr_out_if.source        result
);
    import mbr_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    branch_item_t in_item_reg;
    logic         res_valid_reg;
    logic         res_valid_next;
    result_item_t res_item_reg;
    result_item_t res_item_next;

    logic         accept_in;
    logic         advance;

    logic [WordWidth-1:0] imm_offset;
    logic [WordWidth-1:0] rel_target;
    logic [WordWidth-1:0] abs_target;
    logic [WordWidth-1:0] target;
    logic                 rs_neg;
    logic                 rs_zero;
    logic                 cond;
    logic                 link;
    logic [RegWidth-1:0]  link_reg;
    logic                 fault;

    // Handshake: the input register moves on when the result register is free or drains.
    assign advance      = !res_valid_reg || result.ready;
    assign branch.ready = !in_valid_reg || advance;
    assign accept_in    = branch.valid && branch.ready;

    // Occupancy of the two registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (in_valid_reg && advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_item_reg.kind          <= branch.kind;
            in_item_reg.instr_word    <= branch.instr_word;
            in_item_reg.rs_value      <= branch.rs_value;
            in_item_reg.rt_value      <= branch.rt_value;
            in_item_reg.pc_after_slot <= branch.pc_after_slot;
            in_item_reg.in_slot       <= branch.in_slot;
        end
        if (in_valid_reg && advance)
        begin
            res_item_reg <= res_item_next;
        end
    end

    // Branch targets: relative from the delay slot, absolute within the PC region.
    assign imm_offset = {{(WordWidth - 18){in_item_reg.instr_word[15]}},
                         in_item_reg.instr_word[15:0], 2'b00};
    assign rel_target = in_item_reg.pc_after_slot + imm_offset - INSTR_BYTES;
    assign abs_target = (in_item_reg.pc_after_slot & JUMP_REGION_MASK)
                      | {4'b0000, in_item_reg.instr_word[25:0], 2'b00};
    assign rs_neg     = in_item_reg.rs_value[WordWidth-1];
    assign rs_zero    = (in_item_reg.rs_value == '0);

    // Condition, target and link per kind.
    always_comb
    begin
        cond     = 1'b0;
        link     = 1'b0;
        link_reg = '0;
        target   = in_item_reg.pc_after_slot;
        case (in_item_reg.kind)
            KIND_J:
            begin
                cond   = 1'b1;
                target = abs_target;
            end
            KIND_JAL:
            begin
                cond     = 1'b1;
                target   = abs_target;
                link     = 1'b1;
                link_reg = LINK_REG_RA;
            end
            KIND_JR:
            begin
                cond   = 1'b1;
                target = in_item_reg.rs_value;
            end
            KIND_JALR:
            begin
                cond     = 1'b1;
                target   = in_item_reg.rs_value;
                link     = 1'b1;
                link_reg = in_item_reg.instr_word[15:11];
            end
            KIND_BEQ:
            begin
                cond   = (in_item_reg.rs_value == in_item_reg.rt_value);
                target = rel_target;
            end
            KIND_BNE:
            begin
                cond   = (in_item_reg.rs_value != in_item_reg.rt_value);
                target = rel_target;
            end
            KIND_BLEZ:
            begin
                cond   = rs_neg || rs_zero;
                target = rel_target;
            end
            KIND_BGTZ:
            begin
                cond   = !rs_neg && !rs_zero;
                target = rel_target;
            end
            KIND_REGIMM:
            begin
                // Bit 16 inverts the sign test; the link forms link even when not taken.
                cond   = rs_neg ^ in_item_reg.instr_word[16];
                target = rel_target;
                if (in_item_reg.instr_word[20:17] == REGIMM_LINK_CODE)
                begin
                    link     = 1'b1;
                    link_reg = LINK_REG_RA;
                end
            end
            default:
            begin
                cond = 1'b0;
            end
        endcase
    end

    // A taken branch in a delay slot faults and suppresses the jump and the link.
    assign fault = cond && in_item_reg.in_slot;

    always_comb
    begin
        res_item_next.fault      = fault;
        res_item_next.taken      = cond && !fault;
        res_item_next.new_pc     = (cond && !fault) ? target : in_item_reg.pc_after_slot;
        res_item_next.link_write = link && !fault;
        res_item_next.link_reg   = (link && !fault) ? link_reg : '0;
        res_item_next.link_value = (link && !fault) ? in_item_reg.pc_after_slot : '0;
    end

    // Result channel.
    assign result.valid      = res_valid_reg;
    assign result.new_pc     = res_item_reg.new_pc;
    assign result.taken      = res_item_reg.taken;
    assign result.link_write = res_item_reg.link_write;
    assign result.link_reg   = res_item_reg.link_reg;
    assign result.link_value = res_item_reg.link_value;
    assign result.fault      = res_item_reg.fault;

endmodule

// ----- sim/mbr_checker.sv -----
// Scoreboard that predicts every branch resolution and checks the result channel.
`timescale 1ns / 100ps

module mbr_checker (
    input  logic clk,
    input  logic rst_n,
    mbr_in_if    branch,
    mbr_out_if   result,
    output int   mismatch_count,
    output int   pending_count,
    output int   checked_count,
    output int   taken_count,
    output int   link_count,
    output int   fault_count
);
    import mbr_pkg::*;

    localparam int ReportLimit = 10;

    // Resolutions predicted for accepted branch items, oldest first.
    result_item_t resolved_q[$];

    // Works out the resolution of one branch item.
    function automatic result_item_t resolve_branch(input branch_item_t b);
        result_item_t            r;
        logic [WordWidth-1:0]    offset;
        logic [WordWidth-1:0]    rel_target;
        logic [WordWidth-1:0]    abs_target;
        logic [WordWidth-1:0]    target;
        logic                    go;
        logic                    links;
        logic [RegWidth-1:0]     dest;

        offset     = {{14{b.instr_word[15]}}, b.instr_word[15:0], 2'b00};
        rel_target = b.pc_after_slot - INSTR_BYTES + offset;
        abs_target = (b.pc_after_slot & JUMP_REGION_MASK) | {4'b0, b.instr_word[25:0], 2'b00};
        go     = 1'b0;
        links  = 1'b0;
        dest   = '0;
        target = b.pc_after_slot;

        case (b.kind)
            KIND_J:
            begin
                go     = 1'b1;
                target = abs_target;
            end
            KIND_JAL:
            begin
                go     = 1'b1;
                target = abs_target;
                links  = 1'b1;
                dest   = LINK_REG_RA;
            end
            KIND_JR:
            begin
                go     = 1'b1;
                target = b.rs_value;
            end
            KIND_JALR:
            begin
                go     = 1'b1;
                target = b.rs_value;
                links  = 1'b1;
                dest   = b.instr_word[15:11];
            end
            KIND_BEQ:
            begin
                go     = (b.rs_value == b.rt_value);
                target = rel_target;
            end
            KIND_BNE:
            begin
                go     = (b.rs_value != b.rt_value);
                target = rel_target;
            end
            KIND_BLEZ:
            begin
                go     = b.rs_value[31] || (b.rs_value == '0);
                target = rel_target;
            end
            KIND_BGTZ:
            begin
                go     = !b.rs_value[31] && (b.rs_value != '0);
                target = rel_target;
            end
            KIND_REGIMM:
            begin
                // Bit 16 turns the less-than-zero test into greater-or-equal.
                go     = b.rs_value[31] ^ b.instr_word[16];
                target = rel_target;
                if (b.instr_word[20:17] == REGIMM_LINK_CODE)
                begin
                    links = 1'b1;
                    dest  = LINK_REG_RA;
                end
            end
            default:
            begin
            end
        endcase

        // A taken branch inside a delay slot faults and suppresses everything else.
        r.fault = go && b.in_slot;
        if (r.fault)
        begin
            go    = 1'b0;
            links = 1'b0;
        end

        r.new_pc     = go ? target : b.pc_after_slot;
        r.taken      = go;
        r.link_write = links;
        r.link_reg   = links ? dest : '0;
        r.link_value = links ? b.pc_after_slot : '0;
        return r;
    endfunction

    // Predict on every accepted branch item, compare on every accepted result item.
    always @(posedge clk or negedge rst_n)
    begin
        branch_item_t incoming;
        result_item_t want;
        result_item_t seen;
        string        bad;

        if (!rst_n)
        begin
            resolved_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
            checked_count  <= 0;
            taken_count    <= 0;
            link_count     <= 0;
            fault_count    <= 0;
        end
        else
        begin
            if (branch.valid && branch.ready)
            begin
                incoming.kind          = branch.kind;
                incoming.instr_word    = branch.instr_word;
                incoming.rs_value      = branch.rs_value;
                incoming.rt_value      = branch.rt_value;
                incoming.pc_after_slot = branch.pc_after_slot;
                incoming.in_slot       = branch.in_slot;
                resolved_q.push_back(resolve_branch(incoming));
            end

            if (result.valid && result.ready)
            begin
                seen.new_pc     = result.new_pc;
                seen.taken      = result.taken;
                seen.link_write = result.link_write;
                seen.link_reg   = result.link_reg;
                seen.link_value = result.link_value;
                seen.fault      = result.fault;
                checked_count  <= checked_count + 1;

                if (resolved_q.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < ReportLimit)
                        $display("%t: result item %0d arrived with no branch item pending",
                                 $realtime, checked_count);
                end
                else
                begin
                    want = resolved_q.pop_front();
                    taken_count <= taken_count + int'(want.taken);
                    link_count  <= link_count + int'(want.link_write);
                    fault_count <= fault_count + int'(want.fault);

                    bad = "";
                    if (seen.new_pc !== want.new_pc)         bad = {bad, " new_pc"};
                    if (seen.taken !== want.taken)           bad = {bad, " taken"};
                    if (seen.link_write !== want.link_write) bad = {bad, " link_write"};
                    if (seen.link_reg !== want.link_reg)     bad = {bad, " link_reg"};
                    if (seen.link_value !== want.link_value) bad = {bad, " link_value"};
                    if (seen.fault !== want.fault)           bad = {bad, " fault"};

                    if (bad != "")
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < ReportLimit)
                        begin
                            $display("%t: result item %0d wrong in%s",
                                     $realtime, checked_count, bad);
                            $display("  expected pc=%h taken=%b link=%b reg=%0d value=%h fault=%b",
                                     want.new_pc, want.taken, want.link_write, want.link_reg,
                                     want.link_value, want.fault);
                            $display("  actual   pc=%h taken=%b link=%b reg=%0d value=%h fault=%b",
                                     seen.new_pc, seen.taken, seen.link_write, seen.link_reg,
                                     seen.link_value, seen.fault);
                        end
                    end
                end
            end

            pending_count <= resolved_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives branch items, paces the result channel and reports the verdict.
`timescale 1ns / 100ps

module tb_top;
    import mbr_pkg::*;

    localparam int MaxGap         = 18;
    localparam int LongHoldCycles = 120;
    localparam int BurstItems     = 30;
    localparam int RandomItems    = 700;
    localparam int StretchItems   = 50;
    localparam int DrainCycles    = 8;

    // Kind codes the block treats as no-ops.
    localparam logic [KindWidth-1:0] KindUnusedLow  = 4'd9;
    localparam logic [KindWidth-1:0] KindUnusedHigh = 4'd15;

    logic clk;
    logic rst_n;
    bit   hold_off_req;
    int   sent_count;
    int   directed_items;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int taken_count;
    int link_count;
    int fault_count;

    mbr_in_if  branch_ch ();
    mbr_out_if result_ch ();

    mips_branch_resolve dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch_ch),
        .result (result_ch)
    );

    mbr_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .branch         (branch_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .taken_count    (taken_count),
        .link_count     (link_count),
        .fault_count    (fault_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before the next item; none during calm stretches.
    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MaxGap);
    endfunction

    // Register values biased toward the sign and zero boundaries.
    function automatic logic [WordWidth-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Offers one branch item after an idle gap and waits until it is taken.
    task automatic offer(input logic [KindWidth-1:0] kind,
                         input logic [WordWidth-1:0] iw,
                         input logic [WordWidth-1:0] rs,
                         input logic [WordWidth-1:0] rt,
                         input logic [WordWidth-1:0] pc,
                         input logic                 slot,
                         input int                   gap);
        if (gap > 0)
        begin
            branch_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        branch_ch.valid         <= 1'b1;
        branch_ch.kind          <= kind;
        branch_ch.instr_word    <= iw;
        branch_ch.rs_value      <= rs;
        branch_ch.rt_value      <= rt;
        branch_ch.pc_after_slot <= pc;
        branch_ch.in_slot       <= slot;
        do @(posedge clk); while (!branch_ch.ready);
        sent_count++;
    endtask

    // Offers one branch item with random content, mostly of known kinds.
    task automatic offer_random(input bit calm);
        logic [KindWidth-1:0] kind;
        logic [WordWidth-1:0] iw;
        logic [WordWidth-1:0] rs;
        logic [WordWidth-1:0] rt;
        logic [WordWidth-1:0] pc;

        if ($urandom_range(0, 9) == 0)
            kind = KindWidth'($urandom_range(KindUnusedLow, KindUnusedHigh));
        else
            kind = KindWidth'($urandom_range(KIND_J, KIND_REGIMM));
        iw = $urandom();
        if (kind == KIND_REGIMM && $urandom_range(0, 1) == 1)
            iw[20:17] = REGIMM_LINK_CODE;
        if (kind == KIND_JALR && $urandom_range(0, 7) == 0)
            iw[15:11] = '0;
        rs = pick_word();
        rt = ($urandom_range(0, 2) == 0) ? rs : pick_word();
        pc = ($urandom_range(0, 3) == 0) ? pick_word() : $urandom();
        offer(kind, iw, rs, rt, pc, $urandom_range(0, 3) == 0, pick_gap(calm));
    endtask

    // Stops offering and waits until every predicted result has been checked.
    task automatic wait_drained();
        branch_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Result side: random stalls, calm stretches and one long hold-off on request.
    initial
    begin : result_pacer
        int  stall;
        int  served;
        bit  calm;

        served = 0;
        calm   = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (served % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = LongHoldCycles;
            end
            else
                stall = pick_gap(calm);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            served++;
        end
    end

    // Stimulus and verdict.
    initial
    begin : branch_source
        bit calm;

        sent_count     = 0;
        hold_off_req   = 1'b0;
        calm           = 1'b0;
        rst_n                   <= 1'b0;
        branch_ch.valid         <= 1'b0;
        branch_ch.kind          <= KIND_J;
        branch_ch.instr_word    <= '0;
        branch_ch.rs_value      <= '0;
        branch_ch.rt_value      <= '0;
        branch_ch.pc_after_slot <= '0;
        branch_ch.in_slot       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Jumps: region bits kept, full target field, register targets, rd links.
        offer(KIND_J,    32'h03FF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFC, 1'b0, pick_gap(1'b0));
        offer(KIND_JAL,  32'h0C00_0000, 32'h1, 32'h0, 32'h1234_5678, 1'b0, pick_gap(1'b0));
        offer(KIND_JR,   32'h03E0_0008, 32'hFFFF_FFFF, 32'h0, 32'h4, 1'b0, pick_gap(1'b0));
        // Link to register zero still reports a write.
        offer(KIND_JALR, 32'h0040_0009, 32'h8000_0000, 32'h0, 32'hABCD_0000, 1'b0,
              pick_gap(1'b0));
        offer(KIND_JALR, 32'h0060_F809, 32'h0040_0000, 32'h0, 32'h1000, 1'b0, pick_gap(1'b0));

        // Compare branches, with the largest offsets wrapping around the address space.
        offer(KIND_BEQ,  32'h1000_8000, 32'h5, 32'h5, 32'h0, 1'b0, pick_gap(1'b0));
        offer(KIND_BEQ,  32'h1000_0010, 32'h5, 32'h6, 32'h400, 1'b0, pick_gap(1'b0));
        offer(KIND_BNE,  32'h1400_7FFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 1'b0,
              pick_gap(1'b0));
        offer(KIND_BNE,  32'h1400_0001, 32'h7, 32'h7, 32'h800, 1'b0, pick_gap(1'b0));
        offer(KIND_BLEZ, 32'h1800_FFFF, 32'h0, 32'h0, 32'h100, 1'b0, pick_gap(1'b0));
        offer(KIND_BLEZ, 32'h1800_0002, 32'h8000_0000, 32'h0, 32'h100, 1'b0, pick_gap(1'b0));
        offer(KIND_BLEZ, 32'h1800_0002, 32'h1, 32'h0, 32'h100, 1'b0, pick_gap(1'b0));
        offer(KIND_BGTZ, 32'h1C00_0003, 32'h7FFF_FFFF, 32'h0, 32'h200, 1'b0, pick_gap(1'b0));
        offer(KIND_BGTZ, 32'h1C00_0003, 32'h0, 32'h0, 32'h200, 1'b0, pick_gap(1'b0));

        // Regimm forms: less than zero, greater or equal, and both linking forms.
        offer(KIND_REGIMM, 32'h0400_0004, 32'h8000_0000, 32'h0, 32'h300, 1'b0, pick_gap(1'b0));
        offer(KIND_REGIMM, 32'h0401_FFFF, 32'h0, 32'h0, 32'h300, 1'b0, pick_gap(1'b0));
        offer(KIND_REGIMM, 32'h0410_0003, 32'h1, 32'h0, 32'h300, 1'b0, pick_gap(1'b0));
        offer(KIND_REGIMM, 32'h0411_0003, 32'h5, 32'h0, 32'h300, 1'b0, pick_gap(1'b0));

        // Delay slot: taken branches fault without linking, untaken ones proceed.
        offer(KIND_JAL,    32'h0C12_3456, 32'h0, 32'h0, 32'h5000, 1'b1, pick_gap(1'b0));
        offer(KIND_REGIMM, 32'h0411_0010, 32'h0, 32'h0, 32'h5000, 1'b1, pick_gap(1'b0));
        offer(KIND_REGIMM, 32'h0410_0010, 32'h1, 32'h0, 32'h5000, 1'b1, pick_gap(1'b0));
        offer(KIND_BEQ,    32'h1000_0010, 32'h1, 32'h2, 32'h5000, 1'b1, pick_gap(1'b0));
        offer(KIND_JR,     32'h03E0_0008, 32'h8000, 32'h0, 32'h5000, 1'b1, pick_gap(1'b0));

        // Unused kind codes act as no-ops.
        offer(KindUnusedLow,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h6000, 1'b1,
              pick_gap(1'b0));
        offer(KindUnusedHigh, 32'h0C00_0001, 32'h0, 32'h0, 32'h6004, 1'b0, pick_gap(1'b0));
        directed_items = sent_count;

        // Let the pipeline empty completely before the pressure phase.
        wait_drained();

        // Back-to-back items against a long result hold-off fill the pipeline.
        hold_off_req = 1'b1;
        repeat (BurstItems) offer_random(1'b1);

        // Random traffic with calm stretches mixed in.
        for (int i = 0; i < RandomItems; i++)
        begin
            if (i % StretchItems == 0)
                calm = ($urandom_range(0, 3) == 0);
            offer_random(calm);
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("Resolved %0d branch items (%0d directed) and checked %0d results.",
                 sent_count, directed_items, checked_count);
        $display("Outcomes covered: %0d taken, %0d link writes, %0d delay-slot faults.",
                 taken_count, link_count, fault_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results still pending.", pending_count);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
